/* rtl/mvsv_pkg.sv */
// Shared types and constants for the snapshot visibility block.
// No dependencies; imported by the compare unit and the top level.
package mvsv_pkg;

    // Field widths fixed by the port interface
    localparam int ACTION_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int FIELD_W   = 32;
    localparam int COUNT_W   = 7;

    // Action codes of an input beat
    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SLOT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // Status from the shared comparator
    typedef struct packed {
        logic lt;   // a < b, unsigned
        logic eq;   // a == b
    } t_cmp_res;

endpackage

/* rtl/mvsv_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module mvsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mvsv_cmp.sv */
// Shared unsigned magnitude and equality comparator.
// Uses mvsv_pkg for the result struct.
module mvsv_cmp
    import mvsv_pkg::*;
#(
    parameter int W = 32
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_cmp_res     o_res
);

    // One wide compare serves the slot, bound and scan steps of the sequencer
    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

/* rtl/mvcc_snapshot_visibility.sv */
// Top level: snapshot capture and visibility query sequencer.
// Depends on mvsv_pkg, mvsv_cmp and mvsv_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries start, slot and query
//   beats. Output channel (o_out_valid / i_out_ready) carries a capture
//   report after a slot beat marked last, and an answer for each query.
//   Config channel (i_cfg_valid / o_cfg_ready) writes own_slot; always ready.
// Steps:
//   Start beat: taken in idle, no result.
//   Slot beat: a slot step; a last slot adds an emit step to load the result.
//   Query: the lower bound step decides first, then the horizon step;
//   otherwise the scan of stored ids through the single RAM read port
//   decides, one entry per cycle, and the emit step loads the answer.
//   One beat is processed at a time; o_in_ready is high only when idle.
// Reset: synchronous, active low; clears count, bounds, overflow flag and
//   own_slot. The id store needs no clearing: only written entries are read.
// Stall: a result waits in the output register; the next beat is still
//   accepted, and a further result holds the sequencer until that register
//   is free.
module mvcc_snapshot_visibility
    import mvsv_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int ID_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SLOT_W-1:0]   i_cfg_data,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [FIELD_W-1:0]  i_latest_completed,
    input  logic [SLOT_W-1:0]   i_slot_index,
    input  logic [FIELD_W-1:0]  i_txn_id,
    input  logic                i_last_slot,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic                o_in_snapshot,
    output logic [COUNT_W-1:0]  o_active_count,
    output logic [FIELD_W-1:0]  o_min_active,
    output logic [FIELD_W-1:0]  o_horizon,
    output logic                o_overflow
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_Q_LOW,
        ST_Q_HIGH,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_last, n_last;
    logic [CW-1:0]      r_count, n_count;
    logic [ID_BITS-1:0] r_low, n_low;
    logic [ID_BITS-1:0] r_high, n_high;
    logic               r_ovf, n_ovf;
    logic [SLOT_W-1:0]  r_own, n_own;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_kind, n_kind;
    logic               r_ans, n_ans;

    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic               r_out_hit, n_out_hit;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [FIELD_W-1:0] r_out_min, n_out_min;
    logic [FIELD_W-1:0] r_out_hor, n_out_hor;
    logic               r_out_ovf, n_out_ovf;

    logic [ID_BITS-1:0] w_latest;
    logic [ID_BITS-1:0] w_txn;
    logic               w_in_acc;
    logic               w_keep;
    logic               w_room;
    logic               w_issue;
    logic               w_we;
    logic [ID_BITS-1:0] w_cmp_a, w_cmp_b;
    t_cmp_res           w_cmp;
    logic [ID_BITS-1:0] w_rdata;

    assign w_latest = ID_BITS'(i_latest_completed);
    assign w_txn    = ID_BITS'(i_txn_id);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_keep   = (r_id != '0) && (r_slot != r_own);
    assign w_room   = (r_count < CW'(MAX_SLOTS));
    assign w_issue  = (r_idx < r_count);
    assign w_we     = (r_state == ST_SLOT) && w_keep && w_room;

    // Operand select for the shared comparator
    always_comb begin
        case (r_state)
            ST_Q_HIGH: begin
                w_cmp_a = r_high;
                w_cmp_b = r_id;
            end
            ST_SCAN: begin
                w_cmp_a = w_rdata;
                w_cmp_b = r_id;
            end
            default: begin
                w_cmp_a = r_id;
                w_cmp_b = r_low;
            end
        endcase
    end

    mvsv_cmp #(
        .W (ID_BITS)
    ) u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    // Active id store; written at the fill count, scanned from entry zero
    mvsv_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_ids (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_id),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_slot      = r_slot;
        n_last      = r_last;
        n_count     = r_count;
        n_low       = r_low;
        n_high      = r_high;
        n_ovf       = r_ovf;
        n_own       = r_own;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_kind      = r_kind;
        n_ans       = r_ans;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_hit   = r_out_hit;
        n_out_count = r_out_count;
        n_out_min   = r_out_min;
        n_out_hor   = r_out_hor;
        n_out_ovf   = r_out_ovf;

        if (i_cfg_valid) begin
            n_own = i_cfg_data;
        end

        // Result beat taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_id   = w_txn;
                    n_slot = i_slot_index;
                    n_last = i_last_slot;
                    case (i_action)
                        ACT_START: begin
                            n_high  = w_latest + ID_BITS'(1);
                            n_low   = w_latest + ID_BITS'(1);
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        ACT_SLOT: begin
                            n_state = ST_SLOT;
                        end
                        ACT_QUERY: begin
                            n_kind  = KIND_ANSWER;
                            n_state = ST_Q_LOW;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                if (w_keep) begin
                    if (w_cmp.lt) begin
                        n_low = r_id;
                    end
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                if (r_last) begin
                    n_kind  = KIND_REPORT;
                    n_ans   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_Q_LOW: begin
                // below the minimum: already completed
                if (w_cmp.lt) begin
                    n_ans   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_Q_HIGH;
                end
            end
            ST_Q_HIGH: begin
                // above the horizon: still running
                if (w_cmp.lt) begin
                    n_ans   = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read issued one cycle, compared the next
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend && w_cmp.eq) begin
                    n_ans   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                end else if (!w_issue && !r_pend) begin
                    n_ans   = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_hit   = r_ans;
                    n_out_count = COUNT_W'(r_count);
                    n_out_min   = FIELD_W'(r_low);
                    n_out_hor   = FIELD_W'(r_high);
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_ovf       <= 1'b0;
            r_own       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_low       <= n_low;
            r_high      <= n_high;
            r_ovf       <= n_ovf;
            r_own       <= n_own;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_id        <= n_id;
        r_slot      <= n_slot;
        r_last      <= n_last;
        r_idx       <= n_idx;
        r_kind      <= n_kind;
        r_ans       <= n_ans;
        r_out_kind  <= n_out_kind;
        r_out_hit   <= n_out_hit;
        r_out_count <= n_out_count;
        r_out_min   <= n_out_min;
        r_out_hor   <= n_out_hor;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_in_snapshot  = r_out_hit;
    assign o_active_count = r_out_count;
    assign o_min_active   = r_out_min;
    assign o_horizon      = r_out_hor;
    assign o_overflow     = r_out_ovf;

`ifndef ASSERT_OFF
    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SLOTS))
        else $error("fill count beyond store depth");

    // No write into a full store
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> w_room)
        else $error("store written while full");

    // A result beat only appears out of the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result loaded outside emit step");
`endif

endmodule
